[design/aes_pkg.sv]
package aes_pkg;

    localparam int MaxRoundKeys = 15;
    localparam int KeyIdxW      = 4;
    localparam int BlockW       = 128;
    localparam int CountW       = 4;
    localparam logic [CountW-1:0] MinRoundKeys = 4'd11;
    localparam logic [CountW-1:0] MaxRoundKeysC = 4'd15;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    typedef struct packed {
        logic                load_state;
        logic                do_round;
        logic                last_round;
        logic [KeyIdxW-1:0]  key_addr;
    } aes_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[design/aes_block_encrypt.sv]
// Iterative AES-128/192/256 forward cipher with a 15-slot round key store.
// A load word (tuser=0) writes one round key and gives no result; key index
// 15 is not written. An encrypt word (tuser=1) takes a key fetch step and
// then one round per cycle on a single shared round unit, using
// round_key_count round keys (11 to 15, smaller counts act as 11); the
// next word is accepted once the result has been taken. Round keys are
// read from a registered RAM one slot ahead of the round that uses them.
module aes_block_encrypt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data,       // round_key_count
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,        // key_index[3:0], data_hi[67:4], data_lo[131:68], 0
    input  logic         s_tuser,        // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata         // cipher_hi[63:0], cipher_lo[127:64]
);
    import aes_pkg::*;

    logic [CountW-1:0]  rk_count_reg;
    logic [KeyIdxW-1:0] key_index;
    logic [63:0]        data_hi, data_lo;
    logic               wr_en;
    logic               busy;
    logic [KeyIdxW-1:0] rd_addr;
    logic [127:0]       rd_key;
    logic [127:0]       state;
    logic [127:0]       block_reg;
    aes_cmd_t           cmd;

    assign key_index = s_tdata[3:0];
    assign data_hi   = s_tdata[67:4];
    assign data_lo   = s_tdata[131:68];
    assign wr_en     = s_tvalid && s_tready && (s_tuser == OP_LOAD)
                       && (key_index != 4'hf);
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_count_reg <= MinRoundKeys;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rk_count_reg <= cfg_data;
        end
    end

    // hold the accepted block, the source may move on while key 0 is fetched
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            block_reg <= {data_hi, data_lo};
        end
    end

    aes_ram #(.Width(BlockW), .Depth(16)) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (key_index),
        .wr_data ({data_hi, data_lo}),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    aes_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .is_encrypt (s_tuser == OP_ENCRYPT),
        .rk_count   (rk_count_reg),
        .m_tready   (m_tready),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .busy       (busy),
        .rd_addr    (rd_addr),
        .cmd        (cmd)
    );

    aes_datapath u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .in_block  (block_reg),
        .round_key (rd_key),
        .state     (state)
    );

    assign m_tdata = {state[63:0], state[127:64]};
endmodule

[design/aes_ram.sv]
module aes_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [0:Depth-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[design/aes_datapath.sv]
module aes_datapath (
    input  logic                    clk,
    input  aes_pkg::aes_cmd_t       cmd,
    input  logic [127:0]            in_block,
    input  logic [127:0]            round_key,
    output logic [127:0]            state
);
    import aes_pkg::*;

    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [7:0]   s  [0:15];
    logic [7:0]   t  [0:15];
    logic [7:0]   m  [0:15];
    logic [127:0] rnd;
    logic [7:0]   all;

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            s[k] = state_reg[127-8*k -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[c*4+r] = sbox(s[((c + r) % 4)*4 + r]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int r = 0; r < 4; r++)
            begin
                m[4*c+r] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            rnd[127-8*k -: 8] = cmd.last_round ? t[k] : m[k];
        end
        state_next = state_reg;
        if (cmd.load_state)
        begin
            state_next = in_block ^ round_key;
        end
        else if (cmd.do_round)
        begin
            state_next = rnd ^ round_key;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;
endmodule

[design/aes_ctrl.sv]
module aes_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         is_encrypt,
    input  logic [aes_pkg::CountW-1:0]   rk_count,
    input  logic                         m_tready,
    output logic                         s_tready,
    output logic                         m_tvalid,
    output logic                         busy,
    output logic [aes_pkg::KeyIdxW-1:0]  rd_addr,
    output aes_pkg::aes_cmd_t            cmd
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [KeyIdxW-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic [CountW-1:0]  last_idx;
    logic               hold;

    always_comb
    begin
        if (rk_count < MinRoundKeys)
        begin
            last_idx = MinRoundKeys - 4'd1;
        end
        else
        begin
            last_idx = rk_count - 4'd1;
        end
    end

    // block may not start while a finished word still waits
    assign hold     = out_valid_reg && !m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign busy     = (state_reg != ST_IDLE) || out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        rd_addr        = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (s_tvalid && s_tready && is_encrypt)
                begin
                    state_next = ST_FETCH;
                    round_next = '0;
                end
            end
            ST_FETCH:
            begin
                // key 0 arrives now, fetch key 1
                cmd.load_state = 1'b1;
                rd_addr        = 4'd1;
                round_next     = 4'd1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.do_round   = 1'b1;
                cmd.last_round = (round_reg == last_idx);
                rd_addr        = round_reg + 4'd1;
                round_next     = round_reg + 4'd1;
                if (cmd.last_round)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.key_addr = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next | hold;
        end
    end
endmodule

[design/aes_block_encrypt_chk.sv]
module aes_block_encrypt_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !m_tvalid)
        else $error("load produced a result");
    a_encrypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during encryption");
endmodule

bind aes_block_encrypt aes_block_encrypt_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
